### rtl/core/arac_pkg.sv
// Package for the address range access counter: sizes, action codes,
// item and token types shared by the interfaces, the cell and the top level.
// No dependencies.
package arac_pkg;

  // Table size and address width
  localparam int RANGE_ENTRIES = 16;
  localparam int ADDRESS_BITS  = 48;

  // Fixed field widths of the items
  localparam int INDEX_W = 4;
  localparam int ADDR_W  = 48;
  localparam int END_W   = ADDR_W + 1;
  localparam int COUNT_W = 32;
  localparam int HIT_W   = 5;

  // Cell number width and the width used to match it against an index
  localparam int ID_W    = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
  localparam int MATCH_W = (ID_W > INDEX_W) ? ID_W : INDEX_W;

  localparam logic [63:0]        ADDR_MASK64 = (64'd1 << ADDRESS_BITS) - 64'd1;
  localparam logic [ADDR_W-1:0]  ADDR_MASK   = ADDR_MASK64[ADDR_W-1:0];
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [HIT_W-1:0]   HIT_MAX     = '1;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_READ    = 2'd1,
    ACT_WRITE   = 2'd2,
    ACT_READOUT = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [INDEX_W-1:0]  entry_index;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   length;
  } in_item_t;

  typedef struct packed {
    logic                entry_valid;
    logic [COUNT_W-1:0]  read_count;
    logic [COUNT_W-1:0]  write_count;
    logic [HIT_W-1:0]    hit_count;
  } out_item_t;

  // Item as it travels down the row of cells, with its result so far
  typedef struct packed {
    logic                valid;
    action_t             action;
    logic [INDEX_W-1:0]  entry_index;
    logic [ADDR_W-1:0]   addr;
    logic [END_W-1:0]    addr_end;
    out_item_t           res;
  } token_t;

endpackage

### rtl/core/arac_in_if.sv
// Input channel of the address range access counter: valid/ready and one item.
// Depends on arac_pkg.
interface arac_in_if;
  import arac_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

### rtl/core/arac_out_if.sv
// Result channel of the address range access counter: valid/ready and one item.
// Depends on arac_pkg.
interface arac_out_if;
  import arac_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

### rtl/core/arac_cell.sv
// One cell of the range table: holds one watched range and its counters,
// updates them from the passing item and hands it on through its own register.
// Depends on arac_pkg.
module arac_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  logic [arac_pkg::ID_W-1:0] cell_id,
  input  arac_pkg::token_t       tok_in,
  output arac_pkg::token_t       tok_out
);
  import arac_pkg::*;

  logic [ADDR_W-1:0]  base_r,   base_nxt;
  logic [END_W-1:0]   end_r,    end_nxt;
  logic               valid_r,  valid_nxt;
  logic [COUNT_W-1:0] reads_r,  reads_nxt;
  logic [COUNT_W-1:0] writes_r, writes_nxt;
  token_t             tok_r,    tok_nxt;

  logic sel;
  logic is_access;
  logic hit;

  assign sel       = tok_in.valid &&
                     (MATCH_W'(tok_in.entry_index) == MATCH_W'(cell_id));
  assign is_access = (tok_in.action == ACT_READ) || (tok_in.action == ACT_WRITE);
  // half-open overlap, ends one bit wider
  assign hit = tok_in.valid && is_access && valid_r &&
               ({1'b0, base_r} < tok_in.addr_end) &&
               ({1'b0, tok_in.addr} < end_r);

  always_comb begin
    base_nxt   = base_r;
    end_nxt    = end_r;
    valid_nxt  = valid_r;
    reads_nxt  = reads_r;
    writes_nxt = writes_r;
    tok_nxt    = tok_in;

    if (sel && (tok_in.action == ACT_LOAD)) begin
      base_nxt   = tok_in.addr;
      end_nxt    = tok_in.addr_end;
      valid_nxt  = 1'b1;
      reads_nxt  = '0;
      writes_nxt = '0;
    end

    if (hit) begin
      if (tok_in.action == ACT_READ) begin
        if (reads_r != COUNT_MAX) reads_nxt = reads_r + COUNT_W'(1);
      end else begin
        if (writes_r != COUNT_MAX) writes_nxt = writes_r + COUNT_W'(1);
      end
      if (tok_in.res.hit_count != HIT_MAX) begin
        tok_nxt.res.hit_count = tok_in.res.hit_count + HIT_W'(1);
      end
    end

    if (sel && (tok_in.action == ACT_READOUT)) begin
      tok_nxt.res.entry_valid = valid_r;
      tok_nxt.res.read_count  = reads_r;
      tok_nxt.res.write_count = writes_r;
    end
  end

  // range bounds: no reset, only read once the entry is valid
  always_ff @(posedge clk) begin
    if (advance) begin
      base_r <= base_nxt;
      end_r  <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      reads_r  <= '0;
      writes_r <= '0;
      tok_r    <= '0;
    end else if (advance) begin
      valid_r  <= valid_nxt;
      reads_r  <= reads_nxt;
      writes_r <= writes_nxt;
      tok_r    <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

### rtl/core/address_range_access_counter_top.sv
// Address range access counter, top level: a row of range cells.
// Depends on arac_pkg, arac_in_if, arac_out_if and arac_cell.
//
// Watches up to RANGE_ENTRIES address ranges. Each item is a load (writes a
// range and clears its counters), a read or write access (bumps the matching
// counter of every valid range the access overlaps, and reports how many it
// hit) or a readout (returns one entry's valid mark and counters). Every item
// gives exactly one result. Items walk down a row of RANGE_ENTRIES cells,
// each cell owning one entry, one cell per cycle while the row moves; a new
// item is taken every cycle the row moves, and results leave from the last
// cell's register. When the result register is full and not taken, the
// whole row holds and no item is taken. Counters saturate at all ones.
module address_range_access_counter_top (
  input  logic        clk,
  input  logic        rst_n,
  arac_in_if.sink     in_chan,
  arac_out_if.source  out_chan
);
  import arac_pkg::*;

  token_t tok_head;
  token_t tok_q [RANGE_ENTRIES];
  logic   advance;

  // whole row moves when the last cell's result can leave
  assign advance = !tok_q[RANGE_ENTRIES-1].valid || out_chan.ready;
  assign in_chan.ready = advance;

  // build the travelling item: mask addresses, compute the wide end once
  always_comb begin
    tok_head             = '0;
    tok_head.valid       = in_chan.valid;
    tok_head.action      = in_chan.item.action;
    tok_head.entry_index = in_chan.item.entry_index;
    tok_head.addr        = in_chan.item.address & ADDR_MASK;
    tok_head.addr_end    = {1'b0, in_chan.item.address & ADDR_MASK} +
                           {1'b0, in_chan.item.length & ADDR_MASK};
  end

  for (genvar i = 0; i < RANGE_ENTRIES; i++) begin : g_cell
    token_t tin;
    if (i == 0) begin : g_first
      assign tin = tok_head;
    end else begin : g_next
      assign tin = tok_q[i-1];
    end

    arac_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .cell_id (ID_W'(i)),
      .tok_in  (tin),
      .tok_out (tok_q[i])
    );
  end

  // last cell's register is the result register
  assign out_chan.valid = tok_q[RANGE_ENTRIES-1].valid;
  assign out_chan.item  = tok_q[RANGE_ENTRIES-1].res;

endmodule

### tb/sv/arac_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the address range access counter: watches both channels,
// predicts each result from its own copy of the range table and compares.
// Depends on arac_pkg, arac_in_if and arac_out_if.
module arac_result_checker (
  input  logic clk,
  input  logic rst_n,
  arac_in_if   in_mon,
  arac_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   hit_total
);
  import arac_pkg::*;

  // Shadow range table
  logic [ADDR_W-1:0]  tbl_base [RANGE_ENTRIES];
  logic [ADDR_W-1:0]  tbl_len  [RANGE_ENTRIES];
  logic               tbl_live [RANGE_ENTRIES];
  logic [COUNT_W-1:0] rd_tally [RANGE_ENTRIES];
  logic [COUNT_W-1:0] wr_tally [RANGE_ENTRIES];

  out_item_t expected_q[$];

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Half-open spans, ends one bit wider so nothing wraps
  function automatic logic spans_overlap(input logic [ADDR_W-1:0] a_lo, a_len,
                                         input logic [ADDR_W-1:0] b_lo, b_len);
    logic [END_W-1:0] a_hi;
    logic [END_W-1:0] b_hi;
    a_hi = {1'b0, a_lo} + {1'b0, a_len};
    b_hi = {1'b0, b_lo} + {1'b0, b_len};
    return ({1'b0, a_lo} < b_hi) && ({1'b0, b_lo} < a_hi);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // Applies one item to the shadow table and returns its result
  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t r;
    int idx;
    r   = '0;
    idx = int'(it.entry_index);
    case (it.action)
      ACT_LOAD: begin
        if (idx < RANGE_ENTRIES) begin
          tbl_base[idx] = it.address & ADDR_MASK;
          tbl_len[idx]  = it.length & ADDR_MASK;
          tbl_live[idx] = 1'b1;
          rd_tally[idx] = '0;
          wr_tally[idx] = '0;
        end
      end
      ACT_READOUT: begin
        if (idx < RANGE_ENTRIES) begin
          r.entry_valid = tbl_live[idx];
          r.read_count  = rd_tally[idx];
          r.write_count = wr_tally[idx];
        end
      end
      default: begin
        for (int i = 0; i < RANGE_ENTRIES; i++) begin
          if (tbl_live[i] && spans_overlap(tbl_base[i], tbl_len[i],
                                           it.address & ADDR_MASK,
                                           it.length & ADDR_MASK)) begin
            if (it.action == ACT_READ)
              rd_tally[i] = sat_inc(rd_tally[i]);
            else
              wr_tally[i] = sat_inc(wr_tally[i]);
            if (r.hit_count != HIT_MAX)
              r.hit_count = r.hit_count + 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      for (int i = 0; i < RANGE_ENTRIES; i++) begin
        tbl_base[i] = '0;
        tbl_len[i]  = '0;
        tbl_live[i] = 1'b0;
        rd_tally[i] = '0;
        wr_tally[i] = '0;
      end
      expected_q.delete();
    end else begin
      // new item first: it lands at the back, the front stays the oldest
      if (in_mon.valid && in_mon.ready) begin
        want = predict_result(in_mon.item);
        hit_total += int'(want.hit_count);
        expected_q.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.item;
        if (expected_q.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (got.entry_valid !== want.entry_valid)
            report_mismatch($sformatf("entry_valid got %b want %b",
                                      got.entry_valid, want.entry_valid));
          if (got.read_count !== want.read_count)
            report_mismatch($sformatf("read_count got %0d want %0d",
                                      got.read_count, want.read_count));
          if (got.write_count !== want.write_count)
            report_mismatch($sformatf("write_count got %0d want %0d",
                                      got.write_count, want.write_count));
          if (got.hit_count !== want.hit_count)
            report_mismatch($sformatf("hit_count got %0d want %0d",
                                      got.hit_count, want.hit_count));
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the address range access counter testbench: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on arac_pkg, both channel
// interfaces, address_range_access_counter_top and arac_result_checker.
module testbench;
  import arac_pkg::*;

  logic clk;
  logic rst_n;

  arac_in_if  in_chan ();
  arac_out_if out_chan ();

  int fail_count;
  int pending;
  int checked;
  int hit_total;

  // tallies of what was sent, for the closing summary
  int n_load;
  int n_read;
  int n_write;
  int n_readout;

  // a few clusters of addresses so that random ranges and accesses meet
  logic [ADDR_W-1:0] region [4];

  address_range_access_counter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  arac_result_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .hit_total  (hit_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: the stall pattern drifts in turn through four moods:
  // always ready, mostly ready, long regular stalls, and coin flips.
  logic [11:0] stall_clk;
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_clk      <= '0;
      out_chan.ready <= 1'b0;
    end else begin
      stall_clk <= stall_clk + 1'b1;
      case (stall_clk[9:8])
        2'd0: out_chan.ready <= 1'b1;
        2'd1: out_chan.ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_chan.ready <= (stall_clk[4:0] > 5'd19);
        default: out_chan.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  function automatic logic [ADDR_W-1:0] rand48();
    return ADDR_W'({$urandom, $urandom}) & ADDR_MASK;
  endfunction

  function automatic in_item_t mk_item(input action_t act, input int idx,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [ADDR_W-1:0] len);
    in_item_t it;
    it.action      = act;
    it.entry_index = idx[INDEX_W-1:0];
    it.address     = addr;
    it.length      = len;
    return it;
  endfunction

  // Offers one item and returns at the edge where it was taken. Valid is
  // left high so that a back-to-back item keeps it high without a dip.
  task automatic send_item(input in_item_t it);
    in_chan.item  <= it;
    in_chan.valid <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    case (it.action)
      ACT_LOAD:  n_load++;
      ACT_READ:  n_read++;
      ACT_WRITE: n_write++;
      default:   n_readout++;
    endcase
  endtask

  // Sender gap: drops valid for the given number of cycles
  task automatic hold_off(input int cycles);
    in_chan.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender waits for every outstanding result to come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random item: mostly well-formed traffic around the clusters, with some
  // wide-open noise (full-width addresses and sizes) mixed in.
  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    int r;
    logic [ADDR_W-1:0] len;
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = rand48();
      2:       len = ADDR_MASK;
      default: len = ADDR_W'($urandom_range(1, 600));
    endcase
    it.entry_index = INDEX_W'($urandom);
    it.length      = len;
    if ($urandom_range(0, 9) == 0)
      it.address = rand48();
    else
      it.address = region[r] + ADDR_W'($urandom_range(0, 4095));
    if (pick < 15)       it.action = ACT_LOAD;
    else if (pick < 50)  it.action = ACT_READ;
    else if (pick < 85)  it.action = ACT_WRITE;
    else                 it.action = ACT_READOUT;
    return it;
  endfunction

  // Limit: even the slowest legal run (sender gap, receiver stall, row hold)
  // for under 900 items ends well before this limit.
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    int burst_left;
    // everything the block sees is known from time zero
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.item  = '0;
    n_load    = 0;
    n_read    = 0;
    n_write   = 0;
    n_readout = 0;
    region[0] = rand48();
    region[1] = rand48();
    region[2] = '0;
    region[3] = ADDR_MASK - ADDR_W'(12'h800);

    // Reset once, released at an edge
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed part ----
    // readout of an entry that was never loaded: all zero
    send_item(mk_item(ACT_READOUT, 0, '0, '0));
    send_item(mk_item(ACT_LOAD, 0, 48'h1000, 48'h100));
    // top of the address space with full length: end needs the extra bit
    send_item(mk_item(ACT_LOAD, 15, ADDR_MASK, ADDR_MASK));
    // zero-length range, only hit when an access straddles its start
    send_item(mk_item(ACT_LOAD, 1, 48'h1000, '0));
    send_item(mk_item(ACT_LOAD, 2, '0, ADDR_MASK));
    // last byte of entry 0
    send_item(mk_item(ACT_READ, 5, 48'h10FF, 48'h1));
    // just past entry 0: touching ends do not overlap
    send_item(mk_item(ACT_WRITE, 10, 48'h1100, 48'h10));
    // straddles the zero-length range at 0x1000
    send_item(mk_item(ACT_READ, 0, 48'h0FFF, 48'h2));
    // zero-size access strictly inside entry 0
    send_item(mk_item(ACT_WRITE, 3, 48'h1080, '0));
    // zero-size access exactly at a range start: no hit on that range
    send_item(mk_item(ACT_READ, 7, 48'h1000, '0));
    // highest address, widest size
    send_item(mk_item(ACT_WRITE, 15, ADDR_MASK, ADDR_MASK));
    send_item(mk_item(ACT_READ, 15, '0, ADDR_MASK));
    hold_off(3);
    send_item(mk_item(ACT_READOUT, 0, '0, '0));
    send_item(mk_item(ACT_READOUT, 1, ADDR_MASK, ADDR_MASK));
    send_item(mk_item(ACT_READOUT, 2, '0, '0));
    send_item(mk_item(ACT_READOUT, 15, '0, '0));
    // reload clears the counters of entry 0
    send_item(mk_item(ACT_LOAD, 0, 48'h2000, 48'h10));
    send_item(mk_item(ACT_READOUT, 0, '0, '0));
    send_item(mk_item(ACT_READOUT, 9, '0, '0));
    drain();

    // ---- Random part, in bursts with random gaps ----
    burst_left = $urandom_range(1, 30);
    for (int n = 0; n < 800; n++) begin
      send_item(random_item());
      if (n % 200 == 199) begin
        drain();
      end else if (--burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        // now and then no gap at all between bursts
        if ($urandom_range(0, 3) != 0)
          hold_off($urandom_range(1, 12));
      end
    end
    in_chan.valid <= 1'b0;

    // Wait for the last results to come back
    while (pending != 0) @(posedge clk);
    repeat (RANGE_ENTRIES + 4) @(posedge clk);

    $display("Covered %0d loads, %0d reads, %0d writes, %0d readouts; %0d results checked.",
             n_load, n_read, n_write, n_readout, checked);
    $display("Accesses overlapped watched ranges %0d times in all.", hit_total);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
